>>> rtl/core/ssd_pkg.sv
// Package for the seven-segment scan and blink driver.
// It holds the command codes, field widths and the character decode table.
// It depends on nothing else.
package ssd_pkg;

   localparam int OP_W      = 3;
   localparam int CHAR_W    = 8;
   localparam int ZONE_W    = 2;
   localparam int ZMODE_W   = 2;
   localparam int SEG_W     = 7;
   localparam int DRIVE_W   = 3;
   localparam int NUM_ZONES = 4;
   localparam int NUM_DIGITS = 3;
   localparam int SCAN_W    = 2;

   typedef logic [OP_W-1:0]    op_type;
   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [ZMODE_W-1:0] zmode_type;
   typedef logic [SEG_W-1:0]   seg_type;

   // Command codes; the remaining codes are ignored.
   localparam op_type OP_TICK     = 3'd0;
   localparam op_type OP_SET_MODE = 3'd1;
   localparam op_type OP_SET_DATA = 3'd2;
   localparam op_type OP_SET_ZONE = 3'd3;
   localparam op_type OP_OFF      = 3'd4;

   // Zone LED modes; mode three lights the LED like mode on.
   localparam zmode_type ZMODE_OFF   = 2'd0;
   localparam zmode_type ZMODE_BLINK = 2'd2;

   localparam char_type CHAR_SPACE = 8'h20;
   localparam char_type CHAR_NULL  = 8'h00;
   localparam char_type ANIM_FIRST = 8'h80;
   localparam char_type ANIM_LIMIT = 8'h86;

   localparam logic [SCAN_W-1:0] SCAN_LAST = 2'd2;

   // Character to segment pattern: digits, capitals, dash and the spinner codes.
   function automatic seg_type decode_char(input char_type c);
      seg_type seg;
      unique case (c)
         8'h30: seg = 7'h3F;
         8'h31: seg = 7'h06;
         8'h32: seg = 7'h5B;
         8'h33: seg = 7'h4F;
         8'h34: seg = 7'h66;
         8'h35: seg = 7'h6D;
         8'h36: seg = 7'h7D;
         8'h37: seg = 7'h07;
         8'h38: seg = 7'h7F;
         8'h39: seg = 7'h6F;
         8'h41: seg = 7'h77;
         8'h42: seg = 7'h7C;
         8'h43: seg = 7'h39;
         8'h44: seg = 7'h5E;
         8'h45: seg = 7'h79;
         8'h46: seg = 7'h71;
         8'h47: seg = 7'h6F;
         8'h48: seg = 7'h74;
         8'h49: seg = 7'h10;
         8'h4A: seg = 7'h0E;
         8'h4B: seg = 7'h70;
         8'h4C: seg = 7'h38;
         8'h4D: seg = 7'h37;
         8'h4E: seg = 7'h54;
         8'h4F: seg = 7'h5C;
         8'h50: seg = 7'h73;
         8'h51: seg = 7'h67;
         8'h52: seg = 7'h50;
         8'h53: seg = 7'h6D;
         8'h54: seg = 7'h78;
         8'h55: seg = 7'h1C;
         8'h56: seg = 7'h3E;
         8'h57: seg = 7'h7E;
         8'h58: seg = 7'h64;
         8'h59: seg = 7'h6E;
         8'h5A: seg = 7'h5B;
         8'h2D: seg = 7'h40;
         8'h80: seg = 7'h20;
         8'h81: seg = 7'h10;
         8'h82: seg = 7'h08;
         8'h83: seg = 7'h04;
         8'h84: seg = 7'h02;
         8'h85: seg = 7'h01;
         default: seg = '0;
      endcase
      return seg;
   endfunction

endpackage

>>> rtl/core/ssd_chan_ifs.sv
// Valid/ready channel interfaces for the command and pin-state streams.
// They depend on ssd_pkg for the field widths.
interface ssd_req_if;
   logic                          valid;
   logic                          ready;
   logic [ssd_pkg::OP_W-1:0]      op;
   logic [ssd_pkg::CHAR_W-1:0]    char_first;
   logic [ssd_pkg::CHAR_W-1:0]    char_second;
   logic [ssd_pkg::ZONE_W-1:0]    zone_index;
   logic [ssd_pkg::ZMODE_W-1:0]   zone_mode;

   modport source (output valid, op, char_first, char_second, zone_index, zone_mode,
                   input ready);
   modport sink   (input valid, op, char_first, char_second, zone_index, zone_mode,
                   output ready);
endinterface

interface ssd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ssd_pkg::SEG_W-1:0]      segments;
   logic                           dot;
   logic [ssd_pkg::DRIVE_W-1:0]    digit_drive;
   logic [ssd_pkg::NUM_ZONES-1:0]  zone_leds;
   logic                           power_led;

   modport source (output valid, segments, dot, digit_drive, zone_leds, power_led,
                   input ready);
   modport sink   (input valid, segments, dot, digit_drive, zone_leds, power_led,
                   output ready);
endinterface

>>> rtl/core/seven_segment_scan_blink_driver_core.sv
// Top level of the seven-segment scan and blink driver.
// It depends on ssd_pkg and on the channel interfaces in ssd_chan_ifs.sv.
//
//   Channel   Direction  Handshake       Beat
//   req_bus   in         valid / ready   one command (op, characters, zone fields)
//   rsp_bus   out        valid / ready   the pin state after that command
//   csr_*     in         write enable    dot blink enable bit
//
// Each command is decoded against the display state and the new pin state
// is registered together with rsp valid on the same edge.
// A command is taken in every cycle in which the result slot is empty or is
// being drained, so back-to-back beats run at one per cycle.
// A stalled result holds req ready low; nothing is lost or repeated.
// Reset (synchronous, active high) blanks the digits, clears all counters and
// zone modes, switches the display off and empties the result slot.
module seven_segment_scan_blink_driver_core #(
   parameter int BLINK_PERIOD_TICKS = 37,
   parameter int ANIM_PERIOD_TICKS  = 5
) (
   input  logic        clock,
   input  logic        reset,
   ssd_req_if.sink     req_bus,
   ssd_rsp_if.source   rsp_bus,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   localparam int BLINK_W = (BLINK_PERIOD_TICKS > 1) ? $clog2(BLINK_PERIOD_TICKS) : 1;
   localparam int ANIM_W  = (ANIM_PERIOD_TICKS > 1) ? $clog2(ANIM_PERIOD_TICKS) : 1;
   localparam logic [BLINK_W-1:0] BLINK_LAST = BLINK_W'(BLINK_PERIOD_TICKS - 1);
   localparam logic [ANIM_W-1:0]  ANIM_LAST  = ANIM_W'(ANIM_PERIOD_TICKS - 1);

   // Display state.
   logic                              dot_blink_enable_ff;
   ssd_pkg::char_type                 digit_chars_ff [ssd_pkg::NUM_DIGITS];
   ssd_pkg::char_type                 digit_chars_in [ssd_pkg::NUM_DIGITS];
   ssd_pkg::zmode_type                zone_modes_ff  [ssd_pkg::NUM_ZONES];
   ssd_pkg::zmode_type                zone_modes_in  [ssd_pkg::NUM_ZONES];
   logic [ssd_pkg::SCAN_W-1:0]        scan_index_ff, scan_index_in;
   logic [BLINK_W-1:0]                blink_count_ff, blink_count_in;
   logic [ANIM_W-1:0]                 anim_count_ff, anim_count_in;
   logic                              blink_flag_ff, blink_flag_in;
   logic                              display_on_ff, display_on_in;

   // Pin state; it is also the payload of the result beat, since it only
   // changes when a command is accepted, which needs the result slot free.
   ssd_pkg::seg_type                  segments_ff, segments_in;
   logic                              dot_ff, dot_in;
   logic [ssd_pkg::DRIVE_W-1:0]       digit_drive_ff, digit_drive_in;
   logic [ssd_pkg::NUM_ZONES-1:0]     zone_leds_ff, zone_leds_in;
   logic                              power_led_ff, power_led_in;
   logic                              rsp_valid_ff;

   logic                              req_accept;
   logic                              blink_wrap;
   logic                              anim_wrap;
   ssd_pkg::char_type                 anim_next_char;
   ssd_pkg::char_type                 scan_char;
   logic [ssd_pkg::SCAN_W-1:0]        zone_sel;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.segments    = segments_ff;
   assign rsp_bus.dot         = dot_ff;
   assign rsp_bus.digit_drive = digit_drive_ff;
   assign rsp_bus.zone_leds   = zone_leds_ff;
   assign rsp_bus.power_led   = power_led_ff;

   assign blink_wrap = (blink_count_ff == BLINK_LAST);
   assign anim_wrap  = (anim_count_ff == ANIM_LAST);
   assign zone_sel   = req_bus.zone_index;

   // The spinner step wraps within 8 bits; anything landing past the last
   // spinner code restarts at the first, while a wrap to zero is kept.
   always_comb begin
      anim_next_char = digit_chars_ff[0] + 8'd1;
      if (anim_next_char >= ssd_pkg::ANIM_LIMIT) begin
         anim_next_char = ssd_pkg::ANIM_FIRST;
      end
   end

   // Next-state logic for one command.
   always_comb begin
      digit_chars_in = digit_chars_ff;
      zone_modes_in  = zone_modes_ff;
      scan_index_in  = scan_index_ff;
      blink_count_in = blink_count_ff;
      anim_count_in  = anim_count_ff;
      blink_flag_in  = blink_flag_ff;
      display_on_in  = display_on_ff;
      segments_in    = segments_ff;
      dot_in         = dot_ff;
      digit_drive_in = digit_drive_ff;
      zone_leds_in   = zone_leds_ff;
      power_led_in   = power_led_ff;
      scan_char      = digit_chars_ff[0];

      unique case (req_bus.op)
         ssd_pkg::OP_TICK: begin
            // A tick while the display is off changes nothing at all.
            if (display_on_ff) begin
               blink_count_in = blink_wrap ? '0 : blink_count_ff + BLINK_W'(1);
               anim_count_in  = anim_wrap  ? '0 : anim_count_ff + ANIM_W'(1);

               // On a blink wrap the flag toggles and blinking zones follow it.
               if (blink_wrap) begin
                  blink_flag_in = !blink_flag_ff;
                  for (int z = 0; z < ssd_pkg::NUM_ZONES; z++) begin
                     if (zone_modes_ff[z] == ssd_pkg::ZMODE_BLINK) begin
                        zone_leds_in[z] = !blink_flag_ff;
                     end
                  end
               end

               if ((digit_chars_ff[0] >= ssd_pkg::ANIM_FIRST) && anim_wrap) begin
                  digit_chars_in[0] = anim_next_char;
               end

               // Advance the scan and show the (possibly just updated) digit.
               if (scan_index_ff >= ssd_pkg::SCAN_LAST) begin
                  scan_index_in = '0;
                  scan_char     = digit_chars_in[0];
                  digit_drive_in = 3'b100;
                  dot_in         = 1'b0;
               end else if (scan_index_ff == 2'd0) begin
                  scan_index_in  = 2'd1;
                  scan_char      = digit_chars_ff[1];
                  digit_drive_in = 3'b010;
                  dot_in         = 1'b0;
               end else begin
                  scan_index_in  = ssd_pkg::SCAN_LAST;
                  scan_char      = digit_chars_ff[2];
                  digit_drive_in = 3'b001;
                  dot_in         = dot_blink_enable_ff && blink_flag_in;
               end
               segments_in = ssd_pkg::decode_char(scan_char);
            end
         end
         ssd_pkg::OP_SET_MODE: begin
            display_on_in     = 1'b1;
            power_led_in      = 1'b1;
            digit_chars_in[0] = req_bus.char_first;
         end
         ssd_pkg::OP_SET_DATA: begin
            display_on_in = 1'b1;
            power_led_in  = 1'b1;
            // A zero second character means a single right-aligned character.
            if (req_bus.char_second != ssd_pkg::CHAR_NULL) begin
               digit_chars_in[1] = req_bus.char_first;
               digit_chars_in[2] = req_bus.char_second;
            end else begin
               digit_chars_in[1] = ssd_pkg::CHAR_NULL;
               digit_chars_in[2] = req_bus.char_first;
            end
         end
         ssd_pkg::OP_SET_ZONE: begin
            display_on_in = 1'b1;
            power_led_in  = 1'b1;
            // The LED is only driven when the mode really changes.
            if (zone_modes_ff[zone_sel] != req_bus.zone_mode) begin
               zone_modes_in[zone_sel] = req_bus.zone_mode;
               zone_leds_in[zone_sel]  = (req_bus.zone_mode != ssd_pkg::ZMODE_OFF);
            end
         end
         ssd_pkg::OP_OFF: begin
            // Segments and dot keep their last values.
            display_on_in  = 1'b0;
            power_led_in   = 1'b0;
            zone_leds_in   = '0;
            digit_drive_in = '0;
         end
         default: begin
            // Unknown commands leave everything as it is.
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_blink_enable_ff <= 1'b0;
         for (int d = 0; d < ssd_pkg::NUM_DIGITS; d++) begin
            digit_chars_ff[d] <= ssd_pkg::CHAR_SPACE;
         end
         for (int z = 0; z < ssd_pkg::NUM_ZONES; z++) begin
            zone_modes_ff[z] <= ssd_pkg::ZMODE_OFF;
         end
         scan_index_ff  <= '0;
         blink_count_ff <= '0;
         anim_count_ff  <= '0;
         blink_flag_ff  <= 1'b0;
         display_on_ff  <= 1'b0;
         segments_ff    <= '0;
         dot_ff         <= 1'b0;
         digit_drive_ff <= '0;
         zone_leds_ff   <= '0;
         power_led_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            dot_blink_enable_ff <= csr_write_data;
         end
         if (req_accept) begin
            digit_chars_ff <= digit_chars_in;
            zone_modes_ff  <= zone_modes_in;
            scan_index_ff  <= scan_index_in;
            blink_count_ff <= blink_count_in;
            anim_count_ff  <= anim_count_in;
            blink_flag_ff  <= blink_flag_in;
            display_on_ff  <= display_on_in;
            segments_ff    <= segments_in;
            dot_ff         <= dot_in;
            digit_drive_ff <= digit_drive_in;
            zone_leds_ff   <= zone_leds_in;
            power_led_ff   <= power_led_in;
         end
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // At most one digit is ever driven.
   a_drive_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(digit_drive_ff))
      else $error("more than one digit driven");

   // The power indicator always mirrors the display on flag.
   a_power_matches_on: assert property (@(posedge clock) disable iff (reset)
      power_led_ff == display_on_ff)
      else $error("power LED out of step with display state");

   // While off no digit is driven.
   a_off_no_drive: assert property (@(posedge clock) disable iff (reset)
      !display_on_ff |-> (digit_drive_ff == '0))
      else $error("digit driven while display off");

   // Every accepted command leaves a result in the slot.
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted command produced no result");

   // The scan only visits the three digits.
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      scan_index_ff != 2'd3)
      else $error("scan index out of range");

endmodule
